@@ hdl/cctt_pkg.sv @@
// ----------------------------------------------------------------------------
// cctt_pkg
// Shared types and constants for the cube cover to truth table core.
// ----------------------------------------------------------------------------
package cctt_pkg;

    localparam int TABLE_W   = 64;
    localparam int FIELD_W   = 6;
    localparam int LUT_K_W   = 3;
    localparam int S_TDATA_W = 16;
    localparam logic [LUT_K_W-1:0] LUT_K_RESET = 3'd6;

    typedef enum logic [1:0] {
        CMD_CUBE       = 2'd0,
        CMD_CONST_ZERO = 2'd1,
        CMD_CONST_ONE  = 2'd2,
        CMD_EMPTY      = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               command;
        logic [FIELD_W-1:0] care_mask;
        logic [FIELD_W-1:0] cube_value;
        logic               out_bit;
        logic               last;
    } in_item_t;

endpackage

@@ hdl/cctt_cube_decode.sv @@
// ----------------------------------------------------------------------------
// cctt_cube_decode
// Expands one cube into the set of minterms it matches, and builds the mask
// of valid table positions for the current LUT size.
// ----------------------------------------------------------------------------
module cctt_cube_decode #(
    parameter int MAX_LUT_INPUTS = 6
) (
    input  logic [cctt_pkg::FIELD_W-1:0]   care_mask,
    input  logic [cctt_pkg::FIELD_W-1:0]   cube_value,
    input  logic [cctt_pkg::LUT_K_W-1:0]   lut_k,
    output logic [(1<<MAX_LUT_INPUTS)-1:0] match,
    output logic [(1<<MAX_LUT_INPUTS)-1:0] table_mask
);

    localparam int IDX_W = MAX_LUT_INPUTS;
    localparam int TW    = 1 << MAX_LUT_INPUTS;

    logic [IDX_W-1:0] care_eff;

    // care bits at or above k are don't care
    always_comb begin
        for (int j = 0; j < IDX_W; j++) begin
            care_eff[j] = care_mask[j] && (cctt_pkg::LUT_K_W'(j) < lut_k);
        end
    end

    always_comb begin
        for (int i = 0; i < TW; i++) begin
            match[i]      = ((IDX_W'(i) ^ cube_value[IDX_W-1:0]) & care_eff) == '0;
            table_mask[i] = (IDX_W'(i) >> lut_k) == '0;
        end
    end

endmodule

@@ hdl/cube_cover_to_truth_table_core.sv @@
// ----------------------------------------------------------------------------
// cube_cover_to_truth_table_core
// Builds a K-input LUT truth table from a sum-of-products cover, one cube
// per transaction, and emits the table after the last cube or a constant.
// ----------------------------------------------------------------------------
//  channel  direction  tdata                               tuser             tlast
//  s_       in         care_mask[5:0] cube_value[11:6]     command[1:0]      last
//                      out_bit[12]
//  m_       out        table_bits[63:0]                    polarity_error    -
//  cfg_     in         lut_inputs[2:0] on cfg_wr_en         -                 -
//
//  one transaction per cycle sustained while m_ accepts results; after the s_ accept edge m_tvalid rises
//  via the input register, then minterm expansion into the result register
//  aresetn synchronous active low; clears cover state and sets lut_inputs to 6
//  a cube without last updates the cover and needs no output slot
//  a result-producing transaction waits in the input register while m_ stalls
// ----------------------------------------------------------------------------
module cube_cover_to_truth_table_core #(
    parameter int MAX_LUT_INPUTS = 6
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cctt_pkg::LUT_K_W-1:0]    cfg_wr_data,   // lut_inputs
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cctt_pkg::S_TDATA_W-1:0]  s_tdata,       // care_mask, cube_value, out_bit
    input  logic [1:0]                      s_tuser,       // command
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cctt_pkg::TABLE_W-1:0]    m_tdata,       // table_bits
    output logic                            m_tuser        // polarity_error
);

    localparam int TW = 1 << MAX_LUT_INPUTS;
    localparam int FW = cctt_pkg::FIELD_W;
    localparam int KW = cctt_pkg::LUT_K_W;

    logic [KW-1:0]       lut_k_reg;
    logic [KW-1:0]       lut_k_eff;

    logic                in_valid_reg;
    cctt_pkg::in_item_t  in_item_reg;

    logic [TW-1:0]       covered_reg,  covered_next;
    logic                polarity_reg, polarity_next;
    logic                seen_reg,     seen_next;
    logic                mismatch_reg, mismatch_next;

    logic                out_valid_reg;
    logic [cctt_pkg::TABLE_W-1:0] out_table_reg, out_table_next;
    logic                out_err_reg,  out_err_next;

    logic [TW-1:0]       match;
    logic [TW-1:0]       table_mask;
    logic                produce;
    logic                in_advance;
    logic                proc;
    logic                out_free;
    logic                is_cube;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lut_k_reg <= cctt_pkg::LUT_K_RESET;
        end else if (cfg_wr_en) begin
            lut_k_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        lut_k_eff = lut_k_reg;
        if (lut_k_reg == '0) begin
            lut_k_eff = KW'(1);
        end else if (lut_k_reg > KW'(MAX_LUT_INPUTS)) begin
            lut_k_eff = KW'(MAX_LUT_INPUTS);
        end
    end

    cctt_cube_decode #(
        .MAX_LUT_INPUTS(MAX_LUT_INPUTS)
    ) u_decode (
        .care_mask (in_item_reg.care_mask),
        .cube_value(in_item_reg.cube_value),
        .lut_k     (lut_k_eff),
        .match     (match),
        .table_mask(table_mask)
    );

    // handshake
    assign is_cube    = in_item_reg.command == cctt_pkg::CMD_CUBE;
    assign produce    = !is_cube || in_item_reg.last;
    assign out_free   = !out_valid_reg || m_tready;
    assign in_advance = !produce || out_free;
    assign proc       = in_valid_reg && in_advance;
    assign s_tready   = !in_valid_reg || in_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.command    <= cctt_pkg::cmd_t'(s_tuser);
            in_item_reg.care_mask  <= s_tdata[FW-1:0];
            in_item_reg.cube_value <= s_tdata[2*FW-1:FW];
            in_item_reg.out_bit    <= s_tdata[2*FW];
            in_item_reg.last       <= s_tlast;
        end
    end

    // cover update and result
    always_comb begin
        logic [TW-1:0] cov_upd;
        logic          pol_upd;
        logic          mis_upd;
        logic [TW-1:0] tbl;
        cov_upd = covered_reg | match;
        pol_upd = seen_reg ? polarity_reg : in_item_reg.out_bit;
        mis_upd = mismatch_reg || (seen_reg && (in_item_reg.out_bit != polarity_reg));
        tbl     = '0;
        covered_next   = covered_reg;
        polarity_next  = polarity_reg;
        seen_next      = seen_reg;
        mismatch_next  = mismatch_reg;
        out_err_next   = 1'b0;
        case (in_item_reg.command)
            cctt_pkg::CMD_CUBE: begin
                tbl          = (pol_upd ? cov_upd : ~cov_upd) & table_mask;
                out_err_next = mis_upd;
            end
            cctt_pkg::CMD_CONST_ZERO: begin
                tbl = '0;
            end
            default: begin
                tbl = table_mask;
            end
        endcase
        out_table_next = cctt_pkg::TABLE_W'(tbl);
        if (proc) begin
            if (produce) begin
                covered_next  = '0;
                polarity_next = 1'b1;
                seen_next     = 1'b0;
                mismatch_next = 1'b0;
            end else begin
                covered_next  = cov_upd;
                polarity_next = pol_upd;
                seen_next     = 1'b1;
                mismatch_next = mis_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            covered_reg  <= '0;
            polarity_reg <= 1'b1;
            seen_reg     <= 1'b0;
            mismatch_reg <= 1'b0;
        end else begin
            covered_reg  <= covered_next;
            polarity_reg <= polarity_next;
            seen_reg     <= seen_next;
            mismatch_reg <= mismatch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc && produce) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && produce) begin
            out_table_reg <= out_table_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_table_reg;
    assign m_tuser  = out_err_reg;

`ifndef SYNTHESIS
    a_const_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && !is_cube) |=> (m_tvalid && !m_tuser))
        else $error("constant command produced a polarity error");

    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && produce) |=> (!seen_reg && !mismatch_reg && covered_reg == '0))
        else $error("cover state not cleared after result");

    a_mismatch_needs_cube: assert property (@(posedge aclk) disable iff (!aresetn)
        mismatch_reg |-> seen_reg)
        else $error("mismatch flagged without a first cube");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !(proc && produce))
        else $error("pending result overwritten");
`endif

endmodule
